// File: hdl/lge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life grid generation engine
// Item codes, register indexes, field widths, controller states and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lge_pkg;

  // Field widths of the item and register ports
  localparam int FUNC_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  // Grid size after reset
  localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 7'd30;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Item operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_GEN   = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_WAIT,
    ST_GEN,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic clr_step;    // clear one cell of both stores
    logic access;      // single-cell write or read issue
    logic read_latch;  // take the read data into the result
    logic gen_start;   // reset scan pointers and window
    logic gen_step;    // advance the generation scan
    logic flip;        // swap current and next store
    logic load_res;    // move the result into the output register
  } lge_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // last cell of the clearing pass
    logic gen_last;    // last cell of the generation written
    logic slot_free;   // output register can take a result
  } lge_sts_t;

endpackage
`default_nettype wire

// File: hdl/lge_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_if: item channels of the life grid generation engine
// Request channel (operation, cell address and cell value) and result channel, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface lge_in_if;
  logic                       valid;
  logic                       ready;
  logic [lge_pkg::FUNC_W-1:0] func;
  logic [lge_pkg::ROW_W-1:0]  row_addr;
  logic [lge_pkg::COL_W-1:0]  col_addr;
  logic                       cell_value;

  modport source (output valid, output func, output row_addr, output col_addr,
                  output cell_value, input ready);
  modport sink   (input valid, input func, input row_addr, input col_addr,
                  input cell_value, output ready);
endinterface

interface lge_out_if;
  logic valid;
  logic ready;
  logic read_value;
  logic range_error;

  modport source (output valid, output read_value, output range_error, input ready);
  modport sink   (input valid, input read_value, input range_error, output ready);
endinterface
`default_nettype wire

// File: hdl/life_grid_generation_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Write or read item: access, wait, then result register when free; one item at a time.
// Generation item: one read per cell through the source store port, streamed
//   through a two-row window.
// Reset: clears the control state, then a clearing pass over all MAX_ROWS*MAX_COLS
//   cells writes both stores dead; no item is accepted until it ends, size
//   registers accept writes throughout.
// ----------------------------------------------------------------------------
// life_grid_generation_engine: B3/S23 life on a bounded grid
// Cell write, cell read and one-generation items over two ping-pong stores,
// with configurable row and column count and no wrap at the edges.
// ----------------------------------------------------------------------------
module life_grid_generation_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lge_in_if.sink                             in_if,
  lge_out_if.source                          out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lge_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import lge_pkg::*;

  lge_cmd_t cmd;
  lge_sts_t sts;
  logic     in_ready;

  // sequencer
  lge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .func_i     (in_if.func),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_if.ready = in_ready;

  // stores, scan and result
  lge_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_func_i         (in_if.func),
    .in_row_addr_i     (in_if.row_addr),
    .in_col_addr_i     (in_if.col_addr),
    .in_cell_value_i   (in_if.cell_value),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .out_read_value_o  (out_if.read_value),
    .out_range_error_o (out_if.range_error),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
`default_nettype wire

// File: hdl/lge_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_ctrl: sequencer of the life grid generation engine
// Runs the clearing pass after reset, takes one item at a time and steps
// the datapath through cell access, generation scan and result hand-off.
// ----------------------------------------------------------------------------
module lge_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [lge_pkg::FUNC_W-1:0] func_i,
  output      logic                       in_ready_o,
  input  wire lge_pkg::lge_sts_t          sts_i,
  output      lge_pkg::lge_cmd_t          cmd_o
);
  import lge_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_WRITE, FUNC_READ: state_d = ST_ACCESS;
            FUNC_GEN:              state_d = ST_GEN;
            default:               state_d = ST_RESP;
          endcase
        end
      end
      ST_ACCESS: state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_RESP;
      ST_GEN: begin
        if (sts_i.gen_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.capture   = in_valid_i;
        cmd_o.gen_start = in_valid_i && (func_i == FUNC_GEN);
      end
      ST_ACCESS: cmd_o.access     = 1'b1;
      ST_WAIT:   cmd_o.read_latch = 1'b1;
      ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        cmd_o.flip     = sts_i.gen_last;
      end
      ST_RESP:   cmd_o.load_res = sts_i.slot_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/lge_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_datapath: grid stores, scan window and result register
// Two one-bit cell stores in ping-pong use, a row-major scan with a
// two-row-plus-three shift window for the neighbor count, the size
// registers and the output register.
// ----------------------------------------------------------------------------
module lge_datapath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lge_pkg::CFG_W-1:0]     cfg_wdata_i,
  // item payload
  input  wire logic [lge_pkg::FUNC_W-1:0]    in_func_i,
  input  wire logic [lge_pkg::ROW_W-1:0]     in_row_addr_i,
  input  wire logic [lge_pkg::COL_W-1:0]     in_col_addr_i,
  input  wire logic                          in_cell_value_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          out_read_value_o,
  output      logic                          out_range_error_o,
  // control
  input  wire lge_pkg::lge_cmd_t             cmd_i,
  output      lge_pkg::lge_sts_t             sts_o
);
  import lge_pkg::*;

  localparam int N      = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(N);
  localparam int LAST_K = N + MAX_COLS;
  localparam int KW     = $clog2(LAST_K + 2);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int MAXW   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int LW     = ($clog2(MAXW + 1) > CFG_W) ? $clog2(MAXW + 1) : CFG_W;
  localparam int SRL    = 2 * MAX_COLS + 3;
  // window taps, index 0 is the newest cell
  localparam int T_TL = 2 * MAX_COLS + 2;
  localparam int T_T  = 2 * MAX_COLS + 1;
  localparam int T_TR = 2 * MAX_COLS;
  localparam int T_L  = MAX_COLS + 2;
  localparam int T_C  = MAX_COLS + 1;
  localparam int T_R  = MAX_COLS;
  localparam int T_BL = 2;
  localparam int T_B  = 1;
  localparam int T_BR = 0;

  // size registers and current store select
  logic [CFG_W-1:0] cfg_cols_q, cfg_rows_q;
  logic             sel_q;
  logic [LW-1:0]    eff_cols, eff_rows;

  // latched item and its result
  logic [FUNC_W-1:0] func_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              val_q;
  logic              res_value_q, res_err_q;
  logic              in_range;
  logic [AW-1:0]     iaddr;

  // scan pointers and pipeline
  logic [KW-1:0]  rk_q, k1_q, k2_q;
  logic [RW-1:0]  rr_q, wr_q;
  logic [CW-1:0]  rc_q, wc_q;
  logic [AW-1:0]  wp_q;
  logic           rd_v_q, rd_m_q, sh_v_q;
  logic [SRL-1:0] sr_q;
  logic           issue, mem_rd, item_rd, rd_en, rd_mask;
  logic [AW-1:0]  ra;
  logic           gen_wr, gen_last, acc_wr;

  // neighbor count
  logic       lm, rm, self_bit, out_region, nxt;
  logic [3:0] cnt;

  // stores
  logic          mem_a_q [N];
  logic          mem_b_q [N];
  logic          rdata_a_q, rdata_b_q, src_bit;
  logic          we_a, we_b, wd_a, wd_b;
  logic [AW-1:0] wa_a, wa_b;

  // output register
  logic out_valid_q, out_value_q, out_err_q, slot_free;

  // effective grid size, clamped to the store size
  always_comb begin
    eff_cols = (LW'(cfg_cols_q) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(cfg_cols_q);
    eff_rows = (LW'(cfg_rows_q) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(cfg_rows_q);
  end

  // item address and range check
  assign in_range = (LW'(row_q) < eff_rows) && (LW'(col_q) < eff_cols);
  assign iaddr    = AW'(row_q) * AW'(MAX_COLS) + AW'(col_q);

  // scan read side
  assign issue   = cmd_i.gen_step && (rk_q <= KW'(LAST_K));
  assign mem_rd  = issue && (rk_q < KW'(N));
  assign item_rd = cmd_i.access && (func_q == FUNC_READ) && in_range;
  assign acc_wr  = cmd_i.access && (func_q == FUNC_WRITE) && in_range;
  assign rd_en   = mem_rd || item_rd;
  assign ra      = cmd_i.gen_step ? rk_q[AW-1:0] : iaddr;
  assign rd_mask = (rk_q < KW'(N)) && (LW'(rr_q) < eff_rows) && (LW'(rc_q) < eff_cols);
  assign src_bit = sel_q ? rdata_b_q : rdata_a_q;

  // write side: cell p trails the newest window cell by one row and one
  assign gen_wr   = sh_v_q && (k2_q >= KW'(MAX_COLS + 1));
  assign gen_last = gen_wr && (wp_q == AW'(N - 1));

  // B3/S23 on the window; left and right columns masked at the row edges
  always_comb begin
    lm         = (wc_q != '0);
    rm         = (wc_q != CW'(MAX_COLS - 1));
    self_bit   = sr_q[T_C];
    cnt        = 4'(sr_q[T_TL] & lm) + 4'(sr_q[T_T]) + 4'(sr_q[T_TR] & rm)
               + 4'(sr_q[T_L] & lm) + 4'(sr_q[T_R] & rm)
               + 4'(sr_q[T_BL] & lm) + 4'(sr_q[T_B]) + 4'(sr_q[T_BR] & rm);
    out_region = (LW'(wr_q) >= eff_rows) || (LW'(wc_q) >= eff_cols);
    nxt        = !out_region && ((cnt == BIRTH_COUNT) ||
                                 (self_bit && (cnt == SURVIVE_COUNT)));
  end

  // store write muxing; the generation writes the store that is not current
  always_comb begin
    we_a = 1'b0;
    wa_a = iaddr;
    wd_a = val_q;
    priority if (cmd_i.clr_step) begin
      we_a = 1'b1;
      wa_a = rk_q[AW-1:0];
      wd_a = 1'b0;
    end else if (gen_wr && sel_q) begin
      we_a = 1'b1;
      wa_a = wp_q;
      wd_a = nxt;
    end else if (acc_wr && !sel_q) begin
      we_a = 1'b1;
    end else begin
      we_a = 1'b0;
    end
  end

  always_comb begin
    we_b = 1'b0;
    wa_b = iaddr;
    wd_b = val_q;
    priority if (cmd_i.clr_step) begin
      we_b = 1'b1;
      wa_b = rk_q[AW-1:0];
      wd_b = 1'b0;
    end else if (gen_wr && !sel_q) begin
      we_b = 1'b1;
      wa_b = wp_q;
      wd_b = nxt;
    end else if (acc_wr && sel_q) begin
      we_b = 1'b1;
    end else begin
      we_b = 1'b0;
    end
  end

  // store a
  always_ff @(posedge clk_i) begin
    if (we_a) mem_a_q[wa_a] <= wd_a;
    if (rd_en) rdata_a_q <= mem_a_q[ra];
  end

  // store b
  always_ff @(posedge clk_i) begin
    if (we_b) mem_b_q[wa_b] <= wd_b;
    if (rd_en) rdata_b_q <= mem_b_q[ra];
  end

  // size registers and store select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= CFG_RESET_SIZE;
      cfg_rows_q <= CFG_RESET_SIZE;
      sel_q      <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_GRID_COLS)) cfg_cols_q <= cfg_wdata_i;
      if (cfg_we_i && (cfg_idx_i == REG_GRID_ROWS)) cfg_rows_q <= cfg_wdata_i;
      if (cmd_i.flip) sel_q <= ~sel_q;
    end
  end

  // scan counters: clearing pass and generation share the read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q   <= '0;
      rr_q   <= '0;
      rc_q   <= '0;
      wr_q   <= '0;
      wc_q   <= '0;
      wp_q   <= '0;
      rd_v_q <= 1'b0;
      sh_v_q <= 1'b0;
    end else begin
      rd_v_q <= issue;
      sh_v_q <= rd_v_q;
      if (cmd_i.gen_start) begin
        rk_q <= '0;
        rr_q <= '0;
        rc_q <= '0;
        wr_q <= '0;
        wc_q <= '0;
        wp_q <= '0;
      end else begin
        if (cmd_i.clr_step || issue) rk_q <= rk_q + 1'b1;
        if (issue) begin
          if (rc_q == CW'(MAX_COLS - 1)) begin
            rc_q <= '0;
            rr_q <= rr_q + 1'b1;
          end else begin
            rc_q <= rc_q + 1'b1;
          end
        end
        if (gen_wr) begin
          wp_q <= wp_q + 1'b1;
          if (wc_q == CW'(MAX_COLS - 1)) begin
            wc_q <= '0;
            wr_q <= wr_q + 1'b1;
          end else begin
            wc_q <= wc_q + 1'b1;
          end
        end
      end
    end
  end

  // window pipeline; cells outside the grid enter as dead
  always_ff @(posedge clk_i) begin
    k1_q   <= rk_q;
    rd_m_q <= rd_mask;
    k2_q   <= k1_q;
    if (cmd_i.gen_start) begin
      sr_q <= '0;
    end else if (rd_v_q) begin
      sr_q <= {sr_q[SRL-2:0], rd_m_q & src_bit};
    end
  end

  // item latch and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q      <= in_func_i;
      row_q       <= in_row_addr_i;
      col_q       <= in_col_addr_i;
      val_q       <= in_cell_value_i;
      res_value_q <= 1'b0;
      res_err_q   <= 1'b0;
    end
    if (cmd_i.access) res_err_q <= !in_range;
    if (cmd_i.read_latch && (func_q == FUNC_READ) && in_range) res_value_q <= src_bit;
  end

  // output register
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_value_q <= res_value_q;
      out_err_q   <= res_err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_value_o  = out_value_q;
  assign out_range_error_o = out_err_q;

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = cmd_i.clr_step && (rk_q == KW'(N - 1));
    sts_o.gen_last  = gen_last;
    sts_o.slot_free = slot_free;
  end

  // The scan ends on the bottom-right cell of the store
  a_gen_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_last |-> (wr_q == RW'(MAX_ROWS - 1)) && (wc_q == CW'(MAX_COLS - 1)))
    else $error("generation ended away from the last cell");

  // Generation writes never collide with clearing or item access
  a_gen_wr_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_wr |-> !cmd_i.clr_step && !cmd_i.access && cmd_i.gen_step)
    else $error("generation write outside the generation scan");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_res |-> slot_free)
    else $error("result register overwritten");

  // The store roles swap only on the last generation write
  a_flip_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flip |-> gen_last)
    else $error("store swap before the generation finished");

endmodule
`default_nettype wire
